// ===== hw/rtl/ttc_pkg.sv =====
`default_nettype none
package ttc_pkg;

  // field widths of the stream payload
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VAL_W   = 8;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [VAL_W-1:0] LINE_FEED = 8'd10;
  localparam logic [VAL_W-1:0] BLANK     = 8'd32;
  localparam logic [VAL_W-1:0] NUL       = 8'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_TTY    = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_CURSOR = 3'd2,
    CMD_COLOR  = 3'd3,
    CMD_SHOW   = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_READ   = 3'd6
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input request taken this cycle
    logic copy;        // scroll copy step
    logic fill;        // fill step at the sweep pointer
    logic fill_blank;  // fill with spaces instead of nul
    logic ptr_clr;     // sweep pointer to cell 0
    logic ptr_bottom;  // sweep pointer to start of last row
    logic load_out;    // capture result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scroll; // pending request wraps past the last row
    logic is_clear;    // pending request clears the screen
    logic copy_end;    // last copy step
    logic fill_end;    // last fill step
    logic out_free;    // output register can take a result
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ttc_ctrl.sv =====
`default_nettype none
module ttc_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  ttc_pkg::dp_status_t  status,
  output ttc_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_INIT    = 6'b000001,
    S_IDLE    = 6'b000010,
    S_COPY    = 6'b000100,
    S_ROWFILL = 6'b001000,
    S_CLEAR   = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.fill = 1'b1;
        if (status.fill_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (status.need_scroll) begin
            cmd.ptr_clr = 1'b1;
            state_nxt   = S_COPY;
          end else if (status.is_clear) begin
            cmd.ptr_clr = 1'b1;
            state_nxt   = S_CLEAR;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (status.copy_end) begin
          cmd.ptr_bottom = 1'b1;
          state_nxt      = S_ROWFILL;
        end
      end
      S_ROWFILL: begin
        cmd.fill       = 1'b1;
        cmd.fill_blank = 1'b1;
        if (status.fill_end) begin
          state_nxt = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.fill = 1'b1;
        if (status.fill_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ttc_datapath.sv =====
`default_nettype none
module ttc_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  ttc_pkg::ctrl_cmd_t               cmd,
  output ttc_pkg::dp_status_t              status,
  input  wire  [ttc_pkg::CMD_W-1:0]        in_command,
  input  wire  [ttc_pkg::VAL_W-1:0]        in_value,
  input  wire  [ttc_pkg::COL_W-1:0]        in_column,
  input  wire  [ttc_pkg::ROW_W-1:0]        in_row,
  input  wire                              out_tready,
  output logic                             out_valid,
  output logic [ttc_pkg::VAL_W-1:0]        read_char,
  output logic [ttc_pkg::VAL_W-1:0]        read_attr,
  output logic [ttc_pkg::COL_W-1:0]        cursor_column,
  output logic [ttc_pkg::ROW_W-1:0]        cursor_line,
  output logic [ttc_pkg::ROW_W-1:0]        shown_row,
  output logic [ttc_pkg::VAL_W-1:0]        current_color
);

  localparam int CELLS = COLS * ROWS;
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);

  // cell store, character in the low byte
  logic [ttc_pkg::CELL_W-1:0] mem [CELLS];
  logic [ttc_pkg::CELL_W-1:0] rd_q_r;

  logic [CW-1:0]            cur_col_r, cur_col_nxt;
  logic [RW-1:0]            cur_row_r, cur_row_nxt;
  logic [ttc_pkg::VAL_W-1:0] attr_r, attr_nxt;
  logic                     vis_r, vis_nxt;
  logic [AW-1:0]            ptr_r;
  logic                     rd_hit_r;
  logic                     out_valid_r;

  logic [ttc_pkg::VAL_W-1:0] rchar_r, rattr_r;
  logic [ttc_pkg::COL_W-1:0] ocol_r;
  logic [ttc_pkg::ROW_W-1:0] oline_r, oshown_r;
  logic [ttc_pkg::VAL_W-1:0] ocolor_r;

  ttc_pkg::cmd_t            op;
  logic                     in_range, wrap, last_row;
  logic [AW-1:0]            cur_addr, in_addr;
  logic                     we, rd_en;
  logic [AW-1:0]            wa, ra;
  logic [ttc_pkg::CELL_W-1:0] wd;

  assign op       = ttc_pkg::cmd_t'(in_command);
  assign in_range = (32'(in_column) < COLS) && (32'(in_row) < ROWS);
  assign cur_addr = AW'(cur_row_r) * AW'(COLS) + AW'(cur_col_r);
  assign in_addr  = AW'(in_row) * AW'(COLS) + AW'(in_column);
  assign wrap     = (in_value == ttc_pkg::LINE_FEED) || (cur_col_r == CW'(COLS - 1));
  assign last_row = (cur_row_r == RW'(ROWS - 1));

  assign status.need_scroll = (op == ttc_pkg::CMD_TTY) && wrap && last_row;
  assign status.is_clear    = (op == ttc_pkg::CMD_CLEAR);
  assign status.copy_end    = (ptr_r == AW'(CELLS - COLS));
  assign status.fill_end    = (ptr_r == AW'(CELLS - 1));
  assign status.out_free    = !out_valid_r || out_tready;

  // cursor, color and visibility updates on an accepted request
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    attr_nxt    = attr_r;
    vis_nxt     = vis_r;
    if (cmd.accept) begin
      case (op)
        ttc_pkg::CMD_TTY: begin
          if (wrap) begin
            cur_col_nxt = '0;
            cur_row_nxt = last_row ? cur_row_r : cur_row_r + RW'(1);
          end else begin
            cur_col_nxt = cur_col_r + CW'(1);
          end
        end
        ttc_pkg::CMD_CURSOR: begin
          cur_col_nxt = (32'(in_column) < COLS) ? CW'(in_column) : CW'(COLS - 1);
          cur_row_nxt = (32'(in_row) < ROWS) ? RW'(in_row) : RW'(ROWS - 1);
        end
        ttc_pkg::CMD_COLOR: attr_nxt = in_value;
        ttc_pkg::CMD_SHOW:  vis_nxt  = (in_value != '0);
        ttc_pkg::CMD_CLEAR: begin
          cur_col_nxt = '0;
          cur_row_nxt = '0;
          attr_nxt    = in_value;
        end
        default: begin
        end
      endcase
    end
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    wa    = ptr_r;
    wd    = {attr_r, cmd.fill_blank ? ttc_pkg::BLANK : ttc_pkg::NUL};
    rd_en = 1'b0;
    ra    = in_addr;
    if (cmd.accept) begin
      if (op == ttc_pkg::CMD_TTY && in_value != ttc_pkg::LINE_FEED) begin
        we = 1'b1;
        wa = cur_addr;
        wd = {attr_r, in_value};
      end else if (op == ttc_pkg::CMD_WRITE && in_range) begin
        we = 1'b1;
        wa = in_addr;
        wd = {attr_r, in_value};
      end
      rd_en = (op == ttc_pkg::CMD_READ) && in_range;
    end else if (cmd.copy) begin
      // read one row ahead, write the cell read in the previous cycle
      we    = (ptr_r != '0);
      wa    = ptr_r - AW'(1);
      wd    = rd_q_r;
      rd_en = !status.copy_end;
      ra    = ptr_r + AW'(COLS);
    end else if (cmd.fill) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      attr_r      <= '0;
      vis_r       <= 1'b1;
      ptr_r       <= '0;
      rd_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      attr_r    <= attr_nxt;
      vis_r     <= vis_nxt;
      if (cmd.ptr_clr) begin
        ptr_r <= '0;
      end else if (cmd.ptr_bottom) begin
        ptr_r <= AW'(CELLS - COLS);
      end else if (cmd.copy || cmd.fill) begin
        ptr_r <= ptr_r + AW'(1);
      end
      if (cmd.accept) begin
        rd_hit_r <= (op == ttc_pkg::CMD_READ) && in_range;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rchar_r  <= rd_hit_r ? rd_q_r[7:0] : '0;
      rattr_r  <= rd_hit_r ? rd_q_r[15:8] : '0;
      ocol_r   <= ttc_pkg::COL_W'(cur_col_r);
      oline_r  <= ttc_pkg::ROW_W'(cur_row_r);
      oshown_r <= vis_r ? ttc_pkg::ROW_W'(cur_row_r) : ttc_pkg::ROW_W'(ROWS);
      ocolor_r <= attr_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign read_char     = rchar_r;
  assign read_attr     = rattr_r;
  assign cursor_column = ocol_r;
  assign cursor_line   = oline_r;
  assign shown_row     = oshown_r;
  assign current_color = ocolor_r;

endmodule
`default_nettype wire

// ===== hw/rtl/teletype_text_console.sv =====
// a command that leaves the screen in place passes from intake through the done state to the result register
// a teletype byte that wraps past the last row scrolls: a copy pass, then a row fill
// clear screen sweeps the whole store, one cell written per cycle by the single write port
// throughput: one request at a time; the next request is taken once the previous result is registered
// reset: synchronous active low; afterwards a pass over every cell zeroes the store
//        while in_tready stays low
`default_nettype none
module teletype_text_console #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // request channel
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [ttc_pkg::IN_TDATA_W-1:0]        in_tdata,  // value[7:0], column[14:8], row[19:15]
  input  wire  [ttc_pkg::CMD_W-1:0]             in_tuser,  // command[2:0]
  // result channel
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [ttc_pkg::OUT_TDATA_W-1:0]       out_tdata  // read_char[7:0], read_attr[15:8],
                                                           // cursor_column[22:16], cursor_line[27:23],
                                                           // shown_row[32:28], current_color[40:33]
);

  ttc_pkg::ctrl_cmd_t  cmd;
  ttc_pkg::dp_status_t status;

  logic [ttc_pkg::VAL_W-1:0] read_char, read_attr, current_color;
  logic [ttc_pkg::COL_W-1:0] cursor_column;
  logic [ttc_pkg::ROW_W-1:0] cursor_line, shown_row;

  // sequencer: request intake, scroll copy, row fill, clear sweep, result hand-off
  ttc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // cell store, cursor and color registers, result register
  ttc_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_command    (in_tuser),
    .in_value      (in_tdata[7:0]),
    .in_column     (in_tdata[14:8]),
    .in_row        (in_tdata[19:15]),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .read_char     (read_char),
    .read_attr     (read_attr),
    .cursor_column (cursor_column),
    .cursor_line   (cursor_line),
    .shown_row     (shown_row),
    .current_color (current_color)
  );

  // pack result fields, low field first, zero padded to whole bytes
  assign out_tdata = {7'd0, current_color, shown_row, cursor_line, cursor_column,
                      read_attr, read_char};

endmodule
`default_nettype wire

// ===== hw/rtl/ttc_checker.sv =====
`default_nettype none
module ttc_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_tvalid,
  input wire                                in_tready,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [ttc_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time: busy right after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in flight");

  // reset starts the clearing pass with nothing on the output
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or valid right after reset");

  // logical cursor always on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[22:16]) < COLS) && (32'(out_tdata[27:23]) < ROWS))
    else $error("cursor off screen");

  // hardware row mirrors the logical row or shows the hidden row
  a_shown_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32:28] == out_tdata[27:23]) ||
                   (out_tdata[32:28] == ttc_pkg::ROW_W'(ROWS)))
    else $error("shown row mismatch");

endmodule

bind teletype_text_console ttc_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_ttc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // screen geometry, matched to the instance below
  localparam int SCR_COLS  = 80;
  localparam int SCR_ROWS  = 25;
  localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;

  // command code outside the package enum, must leave everything alone
  localparam logic [ttc_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam int RANDOM_REQUESTS = 550;
  localparam int QUIET_FROM      = 480;  // no idling on either side from here on
  localparam int HOLD_AT         = 150;  // long receiver hold-off starts here
  localparam int HOLD_CYCLES     = 400;
  localparam int PAUSE_AT        = 300;  // sender waits for an empty pipe here
  localparam int TAIL_CYCLES     = 20;

  // one result as the console reports it
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
    logic [6:0] col;
    logic [4:0] line;
    logic [4:0] shown;
    logic [7:0] color;
  } console_view_t;

  // one row of the directed table; typed rows carry their result by hand
  typedef struct packed {
    logic [ttc_pkg::CMD_W-1:0] cmd;
    logic [7:0]                val;
    logic [6:0]                col;
    logic [4:0]                row;
    logic                      typed;
    console_view_t             want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ttc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;  // value[7:0], column[14:8], row[19:15]
  logic [ttc_pkg::CMD_W-1:0]       in_tuser = '0;  // command[2:0]
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ttc_pkg::OUT_TDATA_W-1:0] out_tdata;      // read_char[7:0], read_attr[15:8],
                                                   // cursor_column[22:16], cursor_line[27:23],
                                                   // shown_row[32:28], current_color[40:33]

  // predicted console state
  logic [15:0] screen [0:SCR_CELLS-1];  // attribute in the high byte, character low
  int          cur_x;
  int          cur_y;
  logic [7:0]  color_now;
  logic        cursor_on;

  console_view_t pending_views [$];
  int            requests_sent = 0;
  int            mismatch_count = 0;
  logic          quiet_tail = 1'b0;
  logic          long_hold = 1'b0;

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  teletype_text_console #(
    .COLS(SCR_COLS),
    .ROWS(SCR_ROWS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // directed table: extremes, every command, the corner cases
  step_row_t directed_steps [0:24] = '{
    // fresh screen after reset, in range and far out of range
    '{ttc_pkg::CMD_READ,   8'h00, 7'd0,   5'd0,  1'b1,
      '{8'h00, 8'h00, 7'd0,  5'd0,  5'd0,  8'h00}},
    '{ttc_pkg::CMD_READ,   8'h00, 7'd127, 5'd31, 1'b1,
      '{8'h00, 8'h00, 7'd0,  5'd0,  5'd0,  8'h00}},
    // cursor saturates to the bottom right cell
    '{ttc_pkg::CMD_CURSOR, 8'h00, 7'd127, 5'd31, 1'b1,
      '{8'h00, 8'h00, 7'd79, 5'd24, 5'd24, 8'h00}},
    // hide keeps the logical row, hardware row goes off screen
    '{ttc_pkg::CMD_SHOW,   8'h00, 7'd0,   5'd0,  1'b1,
      '{8'h00, 8'h00, 7'd79, 5'd24, 5'd25, 8'h00}},
    '{ttc_pkg::CMD_COLOR,  8'hFF, 7'd0,   5'd0,  1'b1,
      '{8'h00, 8'h00, 7'd79, 5'd24, 5'd25, 8'hFF}},
    '{ttc_pkg::CMD_SHOW,   8'h80, 7'd0,   5'd0,  1'b1,
      '{8'h00, 8'h00, 7'd79, 5'd24, 5'd24, 8'hFF}},
    // last cell of the screen, wraps and scrolls
    '{ttc_pkg::CMD_TTY,    8'h41, 7'd0,   5'd0,  1'b0, '0},
    '{ttc_pkg::CMD_READ,   8'h00, 7'd79,  5'd23, 1'b0, '0},
    '{ttc_pkg::CMD_READ,   8'h00, 7'd0,   5'd24, 1'b0, '0},
    // line feed on the bottom row scrolls again
    '{ttc_pkg::CMD_TTY,    ttc_pkg::LINE_FEED, 7'd5, 5'd3, 1'b0, '0},
    '{ttc_pkg::CMD_WRITE,  8'hFF, 7'd79,  5'd24, 1'b0, '0},
    // writes off screen are dropped
    '{ttc_pkg::CMD_WRITE,  8'h5A, 7'd80,  5'd0,  1'b0, '0},
    '{ttc_pkg::CMD_WRITE,  8'h5A, 7'd0,   5'd25, 1'b0, '0},
    '{ttc_pkg::CMD_WRITE,  8'h5A, 7'd127, 5'd31, 1'b0, '0},
    '{ttc_pkg::CMD_READ,   8'h00, 7'd79,  5'd24, 1'b0, '0},
    '{CMD_UNUSED,          8'hFF, 7'd127, 5'd31, 1'b0, '0},
    // end of the top row wraps without a scroll
    '{ttc_pkg::CMD_CURSOR, 8'h00, 7'd79,  5'd0,  1'b1,
      '{8'h00, 8'h00, 7'd79, 5'd0,  5'd0,  8'hFF}},
    '{ttc_pkg::CMD_TTY,    8'h00, 7'd0,   5'd0,  1'b0, '0},
    '{ttc_pkg::CMD_TTY,    8'hFF, 7'd127, 5'd31, 1'b0, '0},
    '{ttc_pkg::CMD_READ,   8'h00, 7'd79,  5'd0,  1'b0, '0},
    // clears: nul cells in the given color, cursor home
    '{ttc_pkg::CMD_CLEAR,  8'h00, 7'd0,   5'd0,  1'b1,
      '{8'h00, 8'h00, 7'd0,  5'd0,  5'd0,  8'h00}},
    '{ttc_pkg::CMD_CLEAR,  8'hA5, 7'd127, 5'd31, 1'b1,
      '{8'h00, 8'h00, 7'd0,  5'd0,  5'd0,  8'hA5}},
    '{ttc_pkg::CMD_READ,   8'h00, 7'd79,  5'd24, 1'b1,
      '{8'h00, 8'hA5, 7'd0,  5'd0,  5'd0,  8'hA5}},
    '{ttc_pkg::CMD_COLOR,  8'h07, 7'd0,   5'd0,  1'b1,
      '{8'h00, 8'h00, 7'd0,  5'd0,  5'd0,  8'h07}},
    '{ttc_pkg::CMD_TTY,    ttc_pkg::LINE_FEED, 7'd0, 5'd0, 1'b0, '0}
  };

  // one line per failure, printing capped so a broken block stays readable
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // apply one request to the predicted state and return the result it causes
  function automatic console_view_t console_apply(input logic [ttc_pkg::CMD_W-1:0] cmd,
                                                  input logic [7:0] val,
                                                  input logic [6:0] col,
                                                  input logic [4:0] row);
    console_view_t v;
    int            addr;
    v = '0;
    addr = int'(row) * SCR_COLS + int'(col);
    case (cmd)
      ttc_pkg::CMD_TTY: begin
        // line feed forces the wrap, anything else lands at the cursor
        if (val == ttc_pkg::LINE_FEED) begin
          cur_x = SCR_COLS;
        end else begin
          screen[cur_y * SCR_COLS + cur_x] = {color_now, val};
          cur_x++;
        end
        if (cur_x >= SCR_COLS) begin
          cur_x = 0;
          cur_y++;
        end
        // past the bottom: shift rows up, blank bottom row in current color
        if (cur_y >= SCR_ROWS) begin
          for (int i = 0; i < SCR_CELLS - SCR_COLS; i++)
            screen[i] = screen[i + SCR_COLS];
          for (int i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
            screen[i] = {color_now, ttc_pkg::BLANK};
          cur_y = SCR_ROWS - 1;
        end
      end
      ttc_pkg::CMD_WRITE: begin
        if (col < SCR_COLS && row < SCR_ROWS)
          screen[addr] = {color_now, val};
      end
      ttc_pkg::CMD_CURSOR: begin
        cur_x = (col < SCR_COLS) ? int'(col) : SCR_COLS - 1;
        cur_y = (row < SCR_ROWS) ? int'(row) : SCR_ROWS - 1;
      end
      ttc_pkg::CMD_COLOR: color_now = val;
      ttc_pkg::CMD_SHOW: cursor_on = (val != 8'h00);
      ttc_pkg::CMD_CLEAR: begin
        for (int i = 0; i < SCR_CELLS; i++)
          screen[i] = {val, ttc_pkg::NUL};
        cur_x = 0;
        cur_y = 0;
        color_now = val;
      end
      ttc_pkg::CMD_READ: begin
        if (col < SCR_COLS && row < SCR_ROWS) begin
          v.ch = screen[addr][7:0];
          v.attr = screen[addr][15:8];
        end
      end
      default: ;
    endcase
    v.col = 7'(cur_x);
    v.line = 5'(cur_y);
    v.shown = cursor_on ? 5'(cur_y) : 5'(SCR_ROWS);
    v.color = color_now;
    return v;
  endfunction

  // idling off in the tail and in every third window of 48 requests
  function automatic bit idling_allowed();
    return !quiet_tail && ((requests_sent / 48) % 3 != 2);
  endfunction

  // offer one request, wait for the handshake, then record what it should produce
  task automatic issue(input logic [ttc_pkg::CMD_W-1:0] cmd, input logic [7:0] val,
                       input logic [6:0] col, input logic [4:0] row,
                       input logic typed = 1'b0, input console_view_t want = '0);
    console_view_t predicted;
    if (idling_allowed() && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {4'b0000, row, col, val};
    do @(posedge clk); while (!in_tready);
    predicted = console_apply(cmd, val, col, row);
    pending_views.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_views.size() != 0);
  endtask

  // compare one result against the oldest expectation
  task automatic check_view(input logic [ttc_pkg::OUT_TDATA_W-1:0] d);
    console_view_t want;
    if (pending_views.size() == 0) begin
      report_mismatch("result with no request pending", 32'd1, 32'd0);
      return;
    end
    want = pending_views.pop_front();
    if (d[7:0] !== want.ch)
      report_mismatch("read_char", 32'(d[7:0]), 32'(want.ch));
    if (d[15:8] !== want.attr)
      report_mismatch("read_attr", 32'(d[15:8]), 32'(want.attr));
    if (d[22:16] !== want.col)
      report_mismatch("cursor_column", 32'(d[22:16]), 32'(want.col));
    if (d[27:23] !== want.line)
      report_mismatch("cursor_line", 32'(d[27:23]), 32'(want.line));
    if (d[32:28] !== want.shown)
      report_mismatch("shown_row", 32'(d[32:28]), 32'(want.shown));
    if (d[40:33] !== want.color)
      report_mismatch("current_color", 32'(d[40:33]), 32'(want.color));
  endtask

  // character mix: mostly printable, some line feeds, some raw bytes
  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      return ttc_pkg::LINE_FEED;
    else if (r < 18)
      return 8'($urandom);
    else
      return 8'($urandom_range(32, 126));
  endfunction

  // result side: random stalls plus the long hold-off
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        check_view(out_tdata);
      if (long_hold) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // long hold-off so the block backs up and stalls its request side
  initial begin : long_backpressure
    do @(posedge clk); while (requests_sent < HOLD_AT);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // safety net against a hung block
  initial begin : watchdog
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // request side: reset, directed table, then random traffic
  initial begin : request_source
    int   pick;
    int   burst;
    logic paused;
    paused = 1'b0;
    // predictor starts from the reset state
    for (int i = 0; i < SCR_CELLS; i++)
      screen[i] = 16'h0000;
    cur_x = 0;
    cur_y = 0;
    color_now = 8'h00;
    cursor_on = 1'b1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i])
      issue(directed_steps[i].cmd, directed_steps[i].val, directed_steps[i].col,
            directed_steps[i].row, directed_steps[i].typed, directed_steps[i].want);

    while (requests_sent < $size(directed_steps) + RANDOM_REQUESTS) begin
      if (requests_sent >= QUIET_FROM)
        quiet_tail <= 1'b1;
      // one sender pause with the pipe fully drained
      if (!paused && requests_sent >= PAUSE_AT) begin
        paused = 1'b1;
        wait_all_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // a run of text, sometimes placed and colored first
        if ($urandom_range(0, 1) == 1)
          issue(ttc_pkg::CMD_CURSOR, 8'($urandom), 7'($urandom), 5'($urandom));
        if ($urandom_range(0, 2) == 0)
          issue(ttc_pkg::CMD_COLOR, 8'($urandom), 7'($urandom), 5'($urandom));
        burst = $urandom_range(3, 12);
        repeat (burst)
          issue(ttc_pkg::CMD_TTY, text_byte(), 7'($urandom), 5'($urandom));
      end else if (pick < 62) begin
        // mostly on screen, sometimes anywhere the fields reach
        if ($urandom_range(0, 3) == 0)
          issue(ttc_pkg::CMD_WRITE, 8'($urandom), 7'($urandom), 5'($urandom));
        else
          issue(ttc_pkg::CMD_WRITE, 8'($urandom), 7'($urandom_range(0, SCR_COLS - 1)),
                5'($urandom_range(0, SCR_ROWS - 1)));
      end else if (pick < 77) begin
        // read back around the cursor row, on screen, or off screen
        case ($urandom_range(0, 2))
          0: issue(ttc_pkg::CMD_READ, 8'($urandom), 7'($urandom_range(0, SCR_COLS - 1)),
                   5'(cur_y));
          1: issue(ttc_pkg::CMD_READ, 8'($urandom), 7'($urandom_range(0, SCR_COLS - 1)),
                   5'($urandom_range(0, SCR_ROWS - 1)));
          default: issue(ttc_pkg::CMD_READ, 8'($urandom), 7'($urandom), 5'($urandom));
        endcase
      end else if (pick < 85) begin
        issue(ttc_pkg::CMD_CURSOR, 8'($urandom), 7'($urandom), 5'($urandom));
      end else if (pick < 90) begin
        issue(ttc_pkg::CMD_COLOR, 8'($urandom), 7'($urandom), 5'($urandom));
      end else if (pick < 95) begin
        // show more often than hide so the hardware row mostly tracks
        issue(ttc_pkg::CMD_SHOW,
              ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
              7'($urandom), 5'($urandom));
      end else if (pick < 97) begin
        issue(CMD_UNUSED, 8'($urandom), 7'($urandom), 5'($urandom));
      end else begin
        // clears are slow, keep them rare
        issue(ttc_pkg::CMD_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
      end
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/ttc_pkg.sv
hw/rtl/ttc_ctrl.sv
hw/rtl/ttc_datapath.sv
hw/rtl/teletype_text_console.sv
hw/rtl/ttc_checker.sv
sim/tb.sv
